FILE: rtl/servo_pulse_to_position_unit_assert.svh
// Assertion macros for the servo pulse to position unit.
// Used inside modules that provide clk_i and rst_ni; no other dependencies.
`ifndef SERVO_PULSE_TO_POSITION_UNIT_ASSERT_SVH
`define SERVO_PULSE_TO_POSITION_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SPP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SPP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/spp_pkg.sv
// Shared types, constants and helper functions for the servo pulse decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package spp_pkg;

  // Widths of the pulse counter and of the saturated position range.
  localparam int CountWidth   = 16;
  localparam int PosWidth     = 32;

  // Widths fixed by the register and field definitions.
  localparam int LenWidth     = 16;
  localparam int CfgPosWidth  = 32;
  localparam int OutPosWidth  = 32;
  localparam int ShiftWidth   = 4;
  localparam int TickWidth    = 8;
  localparam int AccWidth     = 40;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 32;

  localparam int WindowMargin = 200;
  localparam int MaxShift     = 8;
  localparam int KWidth       = $clog2(MaxShift + 1);

  // Mapping datapath widths.
  localparam int DiffWidth    = (CountWidth > LenWidth) ? CountWidth : LenWidth;
  localparam int SpanPosWidth = CfgPosWidth + 1;
  localparam int ProdWidth    = DiffWidth + SpanPosWidth;
  localparam int DivCntWidth  = $clog2(ProdWidth + 1);
  localparam int SatInWidth   = ProdWidth + 2;

  // Job queue between the front and back ends.
  localparam int QDepth       = 2;
  localparam int QPtrWidth    = $clog2(QDepth);

  // Register reset values.
  localparam logic [LenWidth-1:0]           RstMinLen  = LenWidth'(1000);
  localparam logic [LenWidth-1:0]           RstMaxLen  = LenWidth'(2000);
  localparam logic signed [CfgPosWidth-1:0] RstMinPos  = CfgPosWidth'(0);
  localparam logic signed [CfgPosWidth-1:0] RstMaxPos  = CfgPosWidth'(4095);
  localparam logic [ShiftWidth-1:0]         RstShift   = ShiftWidth'(2);
  localparam logic [TickWidth-1:0]          RstTimeout = TickWidth'(50);

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgMinLen  = 3'd0,
    CfgMaxLen  = 3'd1,
    CfgMinPos  = 3'd2,
    CfgMaxPos  = 3'd3,
    CfgShift   = 3'd4,
    CfgTimeout = 3'd5,
    CfgStart   = 3'd6
  } spp_cfg_idx_e;

  typedef struct packed {
    logic pin_level;
    logic slow_tick;
  } spp_in_t;

  typedef struct packed {
    logic signed [OutPosWidth-1:0] cmd_position;
    logic                          drive_enable;
    logic                          position_updated;
    logic                          pulse_rejected;
  } spp_out_t;

  typedef struct packed {
    logic [LenWidth-1:0]           min_pulse_len;
    logic [LenWidth-1:0]           max_pulse_len;
    logic signed [CfgPosWidth-1:0] min_pos;
    logic signed [CfgPosWidth-1:0] max_pos;
    logic [ShiftWidth-1:0]         lpf_shift;
    logic [TickWidth-1:0]          timeout_ticks;
  } spp_cfg_t;

  typedef enum logic [1:0] {
    KindPlain,
    KindAccept,
    KindReject
  } spp_kind_e;

  typedef struct packed {
    spp_kind_e             kind;
    logic [CountWidth-1:0] width;
    logic                  slow_tick;
  } spp_job_t;

  // Shift values above the maximum behave as the maximum.
  function automatic logic [KWidth-1:0] clamp_shift(logic [ShiftWidth-1:0] s);
    return (s > MaxShift) ? KWidth'(MaxShift) : KWidth'(s);
  endfunction

  // Saturate a wide signed value to the signed PosWidth range.
  function automatic logic signed [PosWidth-1:0] sat_pos(logic signed [SatInWidth-1:0] v);
    logic signed [PosWidth-1:0] r;
    if ((v[SatInWidth-1:PosWidth-1] == '0) || (v[SatInWidth-1:PosWidth-1] == '1)) begin
      r = v[PosWidth-1:0];
    end else if (v[SatInWidth-1]) begin
      r = {1'b1, {(PosWidth-1){1'b0}}};
    end else begin
      r = {1'b0, {(PosWidth-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: rtl/servo_pulse_to_position_unit.sv
// Top level of the servo pulse to position unit: configuration registers,
// front end, job queue and back end. Depends on spp_pkg, spp_front,
// spp_queue, spp_back and servo_pulse_to_position_unit_assert.svh.
//
// Usage: every input word is one timebase sample of the servo pin plus a
// slow timeout tick, and every accepted word yields exactly one output word
// with the seek position, drive enable and the updated and rejected flags.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. Configuration writes go through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must issue them only while no word is in flight,
// as the block does not enforce this. A sample that does not end an
// accepted pulse passes through the job queue and the output register;
// such words stream at one per cycle while the back end is idle and the
// receiver does not stall. A falling edge that ends an accepted pulse goes
// through the multiply, the serial divider producing one quotient bit per
// cycle, the mapping, the filter and the output; with equal minimum and
// maximum lengths the multiply and divider are skipped. The front end
// keeps taking samples until the two-entry job queue is full. Reset clears
// the pulse counter, filter, seek position and drive enable and loads the
// register defaults. When the receiver stalls, the output register holds
// its word, the back end waits, the queue fills and then in_stall_o rises.
`timescale 1ns / 1ps

module servo_pulse_to_position_unit import spp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  spp_in_t                 in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output spp_out_t                out_word_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  spp_cfg_t cfg_q;
  logic     start_we;
  logic     q_push, q_pop, q_full, q_empty;
  spp_job_t q_in, q_head;
  logic     back_busy;

  // Register file. The start position is not stored: writing it preloads
  // the filter and seek position in the back end while it is idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse_len <= RstMinLen;
      cfg_q.max_pulse_len <= RstMaxLen;
      cfg_q.min_pos       <= RstMinPos;
      cfg_q.max_pos       <= RstMaxPos;
      cfg_q.lpf_shift     <= RstShift;
      cfg_q.timeout_ticks <= RstTimeout;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMinLen:  cfg_q.min_pulse_len <= cfg_data_i[LenWidth-1:0];
        CfgMaxLen:  cfg_q.max_pulse_len <= cfg_data_i[LenWidth-1:0];
        CfgMinPos:  cfg_q.min_pos       <= $signed(cfg_data_i[CfgPosWidth-1:0]);
        CfgMaxPos:  cfg_q.max_pos       <= $signed(cfg_data_i[CfgPosWidth-1:0]);
        CfgShift:   cfg_q.lpf_shift     <= cfg_data_i[ShiftWidth-1:0];
        CfgTimeout: cfg_q.timeout_ticks <= cfg_data_i[TickWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  assign start_we = cfg_we_i && (cfg_idx_i == CfgStart);

  spp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .job_o      (q_in)
  );

  spp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  spp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .start_we_i    (start_we),
    .start_value_i ($signed(cfg_data_i[CfgPosWidth-1:0])),
    .job_i         (q_head),
    .q_empty_i     (q_empty),
    .pop_o         (q_pop),
    .busy_o        (back_busy),
    .out_valid_o   (out_valid_o),
    .out_word_o    (out_word_o),
    .out_stall_i   (out_stall_i)
  );

  `include "servo_pulse_to_position_unit_assert.svh"

  // A word never reports both an accepted and a rejected pulse.
  `SPP_ASSERT_IMP(a_flags_excl, out_valid_o, !(out_word_o.position_updated && out_word_o.pulse_rejected), "updated and rejected both set")

  // An accepted pulse always turns the drive on.
  `SPP_ASSERT_IMP(a_upd_drive, out_valid_o && out_word_o.position_updated, out_word_o.drive_enable, "position update without drive enable")

  // The job under work stays at the queue head until the back end retires it.
  `SPP_ASSERT_IMP(a_busy_head, back_busy, !q_empty, "back end busy with an empty queue")

endmodule

FILE: rtl/spp_front.sv
// Front end: edge detection, pulse width counting and window classification.
// Depends on spp_pkg; feeds classified jobs into spp_queue.
`timescale 1ns / 1ps

module spp_front import spp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  spp_cfg_t cfg_i,
  input  logic     in_valid_i,
  input  spp_in_t  in_word_i,
  output logic     in_stall_o,
  input  logic     q_full_i,
  output logic     push_o,
  output spp_job_t job_o
);

  localparam int WinWidth = DiffWidth + 2;

  logic                  prev_q, prev_d;
  logic [CountWidth-1:0] wcnt_q, wcnt_d;
  logic                  accept;
  logic [WinWidth-1:0]   w_plus, max_plus;
  logic                  in_window;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  // Window: min - margin < w < max + margin, compared without wrap.
  assign w_plus    = WinWidth'(wcnt_q) + WinWidth'(WindowMargin);
  assign max_plus  = WinWidth'(cfg_i.max_pulse_len) + WinWidth'(WindowMargin);
  assign in_window = (w_plus > WinWidth'(cfg_i.min_pulse_len)) &&
                     (WinWidth'(wcnt_q) < max_plus);

  always_comb begin
    job_o.kind      = KindPlain;
    job_o.width     = wcnt_q;
    job_o.slow_tick = in_word_i.slow_tick;
    wcnt_d          = wcnt_q;
    prev_d          = in_word_i.pin_level;
    if (in_word_i.pin_level && !prev_q) begin
      wcnt_d = CountWidth'(1);
    end else if (in_word_i.pin_level) begin
      if (wcnt_q != '1) begin
        wcnt_d = wcnt_q + CountWidth'(1);
      end
    end else if (prev_q) begin
      job_o.kind = in_window ? KindAccept : KindReject;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      wcnt_q <= '0;
    end else if (accept) begin
      prev_q <= prev_d;
      wcnt_q <= wcnt_d;
    end
  end

endmodule

FILE: rtl/spp_queue.sv
// Short job queue that decouples the front end from the back end.
// Depends on spp_pkg for the job type and depth.
`timescale 1ns / 1ps

module spp_queue import spp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  spp_job_t job_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     empty_o,
  output spp_job_t head_o
);

  spp_job_t               slot_q [QDepth];
  logic [QPtrWidth-1:0]   wr_q, rd_q;
  logic [QPtrWidth:0]     cnt_q;

  assign full_o  = (cnt_q == (QPtrWidth+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrWidth'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrWidth'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPtrWidth+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPtrWidth+1)'(1);
      end
    end
  end

endmodule

FILE: rtl/spp_back.sv
// Back end: linear mapping with a serial divider, low-pass filter, timeout
// and the output register. Depends on spp_pkg; pops jobs from spp_queue.
`timescale 1ns / 1ps

module spp_back import spp_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spp_cfg_t                      cfg_i,
  input  logic                          start_we_i,
  input  logic signed [CfgPosWidth-1:0] start_value_i,
  input  spp_job_t                      job_i,
  input  logic                          q_empty_i,
  output logic                          pop_o,
  output logic                          busy_o,
  output logic                          out_valid_o,
  output spp_out_t                      out_word_o,
  input  logic                          out_stall_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_MAP,
    S_FILT,
    S_EMIT
  } state_e;

  state_e                        state_q, state_d;
  logic [DiffWidth-1:0]          a_q, a_d;
  logic [SpanPosWidth-1:0]       b_q, b_d;
  logic [LenWidth-1:0]           d_q, d_d;
  logic                          neg_q, neg_d;
  logic [ProdWidth-1:0]          prod_q, prod_d;
  logic [LenWidth:0]             rem_q, rem_d;
  logic [DivCntWidth-1:0]        cnt_q, cnt_d;
  logic signed [PosWidth-1:0]    p_q, p_d;
  logic signed [AccWidth-1:0]    acc_q, acc_d;
  logic signed [OutPosWidth-1:0] held_q, held_d;
  logic                          drive_q, drive_d;
  logic [TickWidth-1:0]          idle_q, idle_d;
  logic                          out_valid_q, out_valid_d;
  spp_out_t                      out_q, out_d;

  logic [KWidth-1:0]             k;
  logic                          out_free;
  logic signed [DiffWidth:0]     diff_s;
  logic signed [SpanPosWidth-1:0] range_s;
  logic signed [LenWidth:0]      span_s;
  logic [LenWidth:0]             rem_sh;
  logic                          rem_ge;
  logic [SatInWidth-1:0]         q_ext;
  logic signed [SatInWidth-1:0]  map_sum;
  logic signed [AccWidth-1:0]    acc_sh;

  assign k        = clamp_shift(cfg_i.lpf_shift);
  assign out_free = !out_valid_q || !out_stall_i;
  assign busy_o   = (state_q != S_IDLE);

  // Signed operands of the mapping; the divider works on magnitudes.
  assign diff_s  = (DiffWidth+1)'(job_i.width) - (DiffWidth+1)'(cfg_i.min_pulse_len);
  assign range_s = SpanPosWidth'(cfg_i.max_pos) - SpanPosWidth'(cfg_i.min_pos);
  assign span_s  = (LenWidth+1)'(cfg_i.max_pulse_len) - (LenWidth+1)'(cfg_i.min_pulse_len);

  assign rem_sh  = {rem_q[LenWidth-1:0], prod_q[ProdWidth-1]};
  assign rem_ge  = (rem_sh >= {1'b0, d_q});

  assign q_ext   = SatInWidth'(prod_q);
  assign map_sum = SatInWidth'(cfg_i.min_pos) + (neg_q ? -q_ext : q_ext);

  assign acc_sh  = acc_q >>> k;

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    d_d         = d_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    p_d         = p_q;
    acc_d       = acc_q;
    held_d      = held_q;
    drive_d     = drive_q;
    idle_d      = idle_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_we_i) begin
          held_d = OutPosWidth'(start_value_i);
          acc_d  = AccWidth'(start_value_i) <<< k;
        end else if (!q_empty_i && job_i.kind == KindAccept) begin
          if (span_s == '0) begin
            p_d     = sat_pos(SatInWidth'(cfg_i.min_pos));
            state_d = S_FILT;
          end else begin
            a_d     = diff_s[DiffWidth] ? DiffWidth'(-diff_s) : diff_s[DiffWidth-1:0];
            b_d     = range_s[SpanPosWidth-1] ? SpanPosWidth'(-range_s) : range_s;
            d_d     = span_s[LenWidth] ? LenWidth'(-span_s) : span_s[LenWidth-1:0];
            neg_d   = diff_s[DiffWidth] ^ range_s[SpanPosWidth-1] ^ span_s[LenWidth];
            state_d = S_MUL;
          end
        end else if (!q_empty_i && out_free) begin
          // Plain sample or rejected pulse: only the timeout moves.
          if (job_i.slow_tick) begin
            if (idle_q >= cfg_i.timeout_ticks) begin
              drive_d = 1'b0;
              idle_d  = '0;
            end else begin
              idle_d  = idle_q + TickWidth'(1);
            end
          end
          out_d.cmd_position     = held_q;
          out_d.drive_enable     = drive_d;
          out_d.position_updated = 1'b0;
          out_d.pulse_rejected   = (job_i.kind == KindReject);
          out_valid_d            = 1'b1;
          pop_o                  = 1'b1;
        end
      end
      S_MUL: begin
        prod_d  = ProdWidth'(a_q) * ProdWidth'(b_q);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        // One quotient bit per cycle, most significant first.
        rem_d  = rem_ge ? (rem_sh - {1'b0, d_q}) : rem_sh;
        prod_d = {prod_q[ProdWidth-2:0], rem_ge};
        cnt_d  = cnt_q + DivCntWidth'(1);
        if (cnt_q == DivCntWidth'(ProdWidth - 1)) begin
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        p_d     = sat_pos(map_sum);
        state_d = S_FILT;
      end
      S_FILT: begin
        acc_d   = acc_q - acc_sh + AccWidth'(p_q);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          held_d                 = OutPosWidth'(sat_pos(SatInWidth'(acc_sh)));
          drive_d                = 1'b1;
          idle_d                 = '0;
          out_d.cmd_position     = held_d;
          out_d.drive_enable     = 1'b1;
          out_d.position_updated = 1'b1;
          out_d.pulse_rejected   = 1'b0;
          out_valid_d            = 1'b1;
          pop_o                  = 1'b1;
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      a_q         <= '0;
      b_q         <= '0;
      d_q         <= '0;
      neg_q       <= 1'b0;
      prod_q      <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      p_q         <= '0;
      acc_q       <= '0;
      held_q      <= '0;
      drive_q     <= 1'b0;
      idle_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      a_q         <= a_d;
      b_q         <= b_d;
      d_q         <= d_d;
      neg_q       <= neg_d;
      prod_q      <= prod_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      p_q         <= p_d;
      acc_q       <= acc_d;
      held_q      <= held_d;
      drive_q     <= drive_d;
      idle_q      <= idle_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
